[rtl/ilid_pkg.sv]
// Shared definitions for the indexed list block: field widths, request kind codes,
// and the command bundle from the controller to the datapath.
// No dependencies.
package ilid_pkg;

	localparam int DATA_W       = 32;
	localparam int KIND_W       = 3;
	localparam int POS_W        = 7;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int GROUP_SIZE   = 8;

	localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INS_POS  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd4;

	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	typedef struct packed {
		logic load;    // capture the request fields
		logic exec;    // carry out the request on the cells
		logic finish;  // form the result from the gathered read groups
	} ilid_cmd_t;

endpackage

[rtl/indexed_list_insert_delete.sv]
// Top level of the indexed list block: an ordered list of signed 32-bit values.
// Depends on ilid_pkg, ilid_ctrl and ilid_datapath.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a row of
// register cells and takes one request per transaction: read at a position, insert at
// the head, insert at the tail, insert at a position, or delete at a position. An
// insert moves the cells at and after the target up one place and a delete moves the
// cells after it down one place, all at once, since every cell compares its
// own place with the target. Each request gives exactly one result transaction with
// the value read (all ones unless a read succeeded), an ok flag, and the entry count
// after the request. Out-of-range requests, inserts into a full list and unused kind
// codes change nothing and report ok low. The block works on one request at a time:
// the request is captured at the accepting edge, the cells and the first gather level
// update at the next edge, and the result registers then load from the second gather
// level, so the result is offered from the output state and held while the result
// side stalls. A new request is accepted only once the result has been taken and the
// block is back in idle, so a request is never taken while the last one is in flight.
// The two-level OR gather over groups of eight cells and the return to idle after the
// result set the length of a transaction. There is no clearing pass after reset; only
// the entry count is cleared.
module indexed_list_insert_delete
	import ilid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic        [KIND_W-1:0]  kind,
	input  logic        [POS_W-1:0]   position,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic signed [DATA_W-1:0]  read_value,
	output logic                      ok,
	output logic        [COUNT_W-1:0] count
);

	ilid_cmd_t cmd;

	// The controller only sequences the steps; it accepts a new request once the
	// previous result transaction has been taken.
	ilid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// The datapath holds the cells, the entry count and the result registers, which
	// stay stable while the result transaction is stalled.
	ilid_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.read_value (read_value),
		.ok         (ok),
		.count      (count)
	);

endmodule

[rtl/ilid_ctrl.sv]
// Sequencing controller for the indexed list block.
// Depends on ilid_pkg for the command bundle.
module ilid_ctrl
	import ilid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ilid_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_next = ST_EXEC;
			end
			ST_EXEC: state_next = ST_FIN;
			ST_FIN:  state_next = ST_OUT;
			ST_OUT: begin
				if (!rsp_stall) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign req_stall  = (state_q != ST_IDLE);
	assign rsp_valid  = (state_q == ST_OUT);
	assign cmd.load   = (state_q == ST_IDLE) && req_valid;
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.finish = (state_q == ST_FIN);

	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("load not followed by exec");
	a_exec_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.finish) else $error("exec not followed by finish");
	a_finish_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (rsp_valid && req_stall)) else $error("result not presented");

endmodule

[rtl/ilid_datapath.sv]
// Datapath of the indexed list block: the row of shifting cells, the entry count,
// the grouped read gather, and the result registers.
// Depends on ilid_pkg for widths, kind codes and the command bundle.
module ilid_datapath
	import ilid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ilid_cmd_t                cmd,
	input  logic        [KIND_W-1:0] kind,
	input  logic        [POS_W-1:0]  position,
	input  logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] read_value,
	output logic                     ok,
	output logic        [COUNT_W-1:0] count
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int W      = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam logic [W-1:0] CAP_W = W'(CAPACITY);

	logic        [KIND_W-1:0] kind_q;
	logic        [POS_W-1:0]  pos_q;
	logic signed [DATA_W-1:0] value_q;
	logic        [CNT_W-1:0]  count_q;
	logic signed [DATA_W-1:0] cell_q [CAPACITY];
	logic        [DATA_W-1:0] grp_q [GROUPS];
	logic                     rd_ok_q;
	logic                     ok_q;
	logic signed [DATA_W-1:0] read_value_q;

	logic [W-1:0]      pos_w;
	logic [W-1:0]      cnt_w;
	logic [W-1:0]      tgt_w;
	logic              is_ins;
	logic              ins_ok;
	logic              del_ok;
	logic              rd_ok;
	logic [DATA_W-1:0] masked [GROUPS*GROUP_SIZE];
	logic [DATA_W-1:0] grp_d [GROUPS];
	logic [DATA_W-1:0] gather;

	assign pos_w = W'(pos_q);
	assign cnt_w = W'(count_q);

	always_comb begin
		case (kind_q)
			KIND_INS_HEAD: tgt_w = '0;
			KIND_INS_TAIL: tgt_w = cnt_w;
			default:       tgt_w = pos_w;
		endcase
		is_ins = kind_q inside {KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS};
		ins_ok = is_ins && (cnt_w < CAP_W) && (tgt_w <= cnt_w);
		del_ok = (kind_q == KIND_DELETE) && (pos_w < cnt_w);
		rd_ok  = (kind_q == KIND_READ) && (pos_w < cnt_w);
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			pos_q   <= position;
			value_q <= value;
		end
	end

	// Each cell compares its own place with the target and shifts or holds.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [W-1:0] IDX = W'(i);

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (ins_ok) begin
					if (IDX == tgt_w) begin
						cell_q[i] <= value_q;
					end else if (IDX > tgt_w) begin
						if (i > 0) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
				end else if (del_ok && (IDX >= pos_w)) begin
					if (i < CAPACITY - 1) cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end

		assign masked[i] = (IDX == pos_w) ? cell_q[i] : '0;
	end

	for (genvar i = CAPACITY; i < GROUPS * GROUP_SIZE; i++) begin : g_pad
		assign masked[i] = '0;
	end

	// First level of the read gather: one OR over each group of cells.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				grp_d[g] = grp_d[g] | masked[g * GROUP_SIZE + j];
			end
		end
	end

	// Second level: OR over the registered groups.
	always_comb begin
		gather = '0;
		for (int g = 0; g < GROUPS; g++) begin
			gather = gather | grp_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_q[g] <= grp_d[g];
			end
			rd_ok_q <= rd_ok;
			ok_q    <= rd_ok || ins_ok || del_ok;
		end
		if (cmd.finish) begin
			read_value_q <= rd_ok_q ? $signed(gather) : $signed(MISS_VALUE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (del_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign read_value = read_value_q;
	assign ok         = ok_q;
	assign count      = cnt_w[COUNT_W-1:0];

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_w <= CAP_W) else $error("entry count above capacity");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");
	a_idle_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.exec || (!ins_ok && !del_ok)) |=> $stable(count_q))
		else $error("entry count changed without an insert or delete");

endmodule

[tb/indexed_list_insert_delete_tb.sv]
// Testbench for indexed_list_insert_delete: directed table, then shaped random requests,
// each result checked against a pinned value or a predictor of the list contents and entry count.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL.
module indexed_list_insert_delete_tb;
	import ilid_pkg::*;

	// Kind codes that the block must treat as no-ops.
	localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

	localparam int LIST_CAP         = CAPACITY_DEF;
	localparam int RANDOM_ITEMS     = 1375;
	localparam int PHASE_LEN        = 150;
	localparam int LONG_HOLD_AT     = 500;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 20;
	localparam int QUIET_LIMIT      = 2000;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     ok;
		logic [COUNT_W-1:0]       count;
	} list_result_t;

	// One row of the directed table. Rows with pinned set carry a result that is
	// obvious by inspection; the rest are checked against the predictor.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic              pinned;
		list_result_t      want;
	} dir_row_t;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// Empty list: every request but a legal insert is refused.
		'{KIND_READ,     7'd0,   32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd0}},
		'{KIND_DELETE,   7'd0,   32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd0}},
		'{KIND_INS_POS,  7'd1,   32'd5,        1'b1, '{MISS_VALUE, 1'b0, 7'd0}},
		'{KIND_RSVD5,    7'd0,   32'd5,        1'b1, '{MISS_VALUE, 1'b0, 7'd0}},
		// Build a four-entry list holding the value extremes.
		'{KIND_INS_HEAD, 7'd0,   32'h7FFFFFFF, 1'b1, '{MISS_VALUE, 1'b1, 7'd1}},
		'{KIND_INS_TAIL, 7'd127, 32'h80000000, 1'b1, '{MISS_VALUE, 1'b1, 7'd2}},
		'{KIND_INS_POS,  7'd1,   32'd0,        1'b1, '{MISS_VALUE, 1'b1, 7'd3}},
		'{KIND_INS_POS,  7'd3,   32'hFFFFFFFF, 1'b1, '{MISS_VALUE, 1'b1, 7'd4}},
		'{KIND_READ,     7'd0,   32'd0,        1'b0, '0},
		'{KIND_READ,     7'd1,   32'd0,        1'b0, '0},
		'{KIND_READ,     7'd2,   32'd0,        1'b0, '0},
		'{KIND_READ,     7'd3,   32'd0,        1'b0, '0},
		// Out-of-range positions and unused kinds leave the list alone.
		'{KIND_READ,     7'd4,   32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_READ,     7'd127, 32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_INS_POS,  7'd127, 32'd9,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_INS_POS,  7'd5,   32'd9,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_DELETE,   7'd4,   32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_DELETE,   7'd127, 32'd0,        1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_RSVD6,    7'd64,  32'hAAAAAAAA, 1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		'{KIND_RSVD7,    7'd127, 32'h55555555, 1'b1, '{MISS_VALUE, 1'b0, 7'd4}},
		// Deletes in the middle and at the head, then a head insert.
		'{KIND_DELETE,   7'd1,   32'd0,        1'b0, '0},
		'{KIND_READ,     7'd1,   32'd0,        1'b0, '0},
		'{KIND_DELETE,   7'd0,   32'd0,        1'b0, '0},
		'{KIND_INS_HEAD, 7'd64,  32'h12345678, 1'b0, '0},
		'{KIND_READ,     7'd0,   32'd0,        1'b0, '0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic        [KIND_W-1:0]  kind = '0;
	logic        [POS_W-1:0]   position = '0;
	logic signed [DATA_W-1:0]  value = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	logic signed [DATA_W-1:0]  read_value;
	logic                      ok;
	logic        [COUNT_W-1:0] count;

	// Side information that travels with the request on the bus: whether its
	// result is pinned by the directed table, and to what.
	logic         cur_pinned = 1'b0;
	list_result_t cur_pinned_result = '0;

	// Shadow copy of the list, updated when a request transaction is accepted.
	logic signed [DATA_W-1:0] list_vals [LIST_CAP];
	int                       list_len = 0;

	list_result_t expected_results [$];
	int           error_count = 0;
	int           result_index = 0;
	int           quiet_cycles = 0;
	bit           send_burst = 1'b0;
	bit           take_burst = 1'b0;

	indexed_list_insert_delete u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.ok         (ok),
		.count      (count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Carries out one request on the shadow list and returns the result it should
	// produce. Inserts shift the tail up a place, deletes shift it down a place.
	function automatic list_result_t apply_request(logic [KIND_W-1:0] k,
			logic [POS_W-1:0] p, logic signed [DATA_W-1:0] v);
		list_result_t r;
		int           slot;
		r.read_value = MISS_VALUE;
		r.ok = 1'b0;
		slot = -1;
		case (k)
			KIND_READ: begin
				if (p < list_len) begin
					r.read_value = list_vals[p];
					r.ok = 1'b1;
				end
			end
			KIND_INS_HEAD: slot = 0;
			KIND_INS_TAIL: slot = list_len;
			KIND_INS_POS:  slot = int'(p);
			KIND_DELETE: begin
				if (p < list_len) begin
					for (int i = int'(p); i < list_len - 1; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		// A full list drops every insert, whatever its position.
		if (slot >= 0 && slot <= list_len && list_len < LIST_CAP) begin
			for (int i = list_len; i > slot; i--)
				list_vals[i] = list_vals[i - 1];
			list_vals[slot] = v;
			list_len++;
			r.ok = 1'b1;
		end
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		$display("MISMATCH: %s", msg);
	endtask

	// Offers one request transaction from the falling edge, holds it until the
	// block takes it, then leaves the bus idle for a drawn number of cycles.
	// A zero gap keeps valid high straight into the next request.
	task automatic drive_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
			logic [DATA_W-1:0] v, logic pinned, list_result_t want);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		kind <= k;
		position <= p;
		value <= v;
		cur_pinned <= pinned;
		cur_pinned_result <= want;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Both handshakes are sampled at the rising edge, before the block's own
	// registers move. An accepted request is pushed through the predictor at once,
	// so the shadow list is always current when the next request is drawn.
	always @(posedge clk) begin : monitor
		list_result_t predicted;
		list_result_t want;
		if (arst_n) begin
			if (req_valid && req_stall === 1'b0) begin
				predicted = apply_request(kind, position, value);
				expected_results.push_back(cur_pinned ? cur_pinned_result : predicted);
			end
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						result_index));
				end else begin
					want = expected_results.pop_front();
					if (read_value !== want.read_value)
						report_mismatch($sformatf("result %0d read_value %0d, expected %0d",
							result_index, read_value, want.read_value));
					if (ok !== want.ok)
						report_mismatch($sformatf("result %0d ok %b, expected %b",
							result_index, ok, want.ok));
					if (count !== want.count)
						report_mismatch($sformatf("result %0d count %0d, expected %0d",
							result_index, count, want.count));
				end
				result_index++;
			end
		end
	end

	// Watchdog: the run is declared hung once no transaction has moved on either
	// side for a long stretch. The long receiver hold-off stays well inside it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("indexed_list_insert_delete verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Result side: before each result it stalls for a drawn number of cycles, or
	// not at all during bursts. Once, well into the run, it holds off for a long
	// stretch while the sender keeps offering, so the block backs up and stalls
	// its request side.
	initial begin : result_side
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				take_burst = !take_burst;
			gap = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(take_burst);
			if (gap > 0) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				rsp_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (rsp_valid !== 1'b1);
			taken++;
		end
	end

	// Request side and end of run.
	initial begin : request_side
		traffic_mode_t mode;
		int            roll;
		int            w_ins;
		int            w_del;
		logic [KIND_W-1:0] k;
		logic [POS_W-1:0]  p;
		logic [DATA_W-1:0] v;
		mode = MODE_GROW;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			drive_request(DIRECTED[i].kind, DIRECTED[i].pos, DIRECTED[i].val,
				DIRECTED[i].pinned, DIRECTED[i].want);

		// Let the directed results drain before the random traffic starts.
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);

		// Random traffic runs in phases that favor growing the list until it is
		// full, shrinking it to empty, or a balanced mix, so that the full-list
		// and empty-list corners are reached many times over.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_LEN == 0)
				mode = traffic_mode_t'($urandom_range(0, 2));
			if (i == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				req_valid <= 1'b0;
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			case (mode)
				MODE_GROW:   begin w_ins = 70; w_del = 12; end
				MODE_SHRINK: begin w_ins = 15; w_del = 60; end
				default:     begin w_ins = 40; w_del = 35; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				k = KIND_RSVD5 + KIND_W'($urandom_range(0, 2));
			end else if (roll < 3 + w_ins) begin
				case ($urandom_range(0, 2))
					0: k = KIND_INS_HEAD;
					1: k = KIND_INS_TAIL;
					default: k = KIND_INS_POS;
				endcase
			end else if (roll < 3 + w_ins + w_del) begin
				k = KIND_DELETE;
			end else begin
				k = KIND_READ;
			end

			// Positions are mostly legal for the current list; one in ten is drawn
			// over the whole field to hit the out-of-range cases.
			if ($urandom_range(0, 9) == 0)
				p = POS_W'($urandom_range(0, 127));
			else if ((k == KIND_READ || k == KIND_DELETE) && list_len > 0)
				p = POS_W'($urandom_range(0, list_len - 1));
			else if (k == KIND_INS_POS)
				p = POS_W'($urandom_range(0, list_len));
			else
				p = POS_W'($urandom_range(0, 127));

			case ($urandom_range(0, 19))
				0: v = 32'h80000000;
				1: v = 32'h7FFFFFFF;
				2: v = 32'h00000000;
				3: v = 32'hFFFFFFFF;
				default: v = $urandom;
			endcase

			drive_request(k, p, v, 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// Wait out a drain stretch to catch any stray result the block might still emit.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		if (error_count == 0)
			$display("indexed_list_insert_delete verification clean");
		else
			$display("indexed_list_insert_delete verification failed");
		$finish;
	end

endmodule
